>>> design/pfe_pkg.sv
`timescale 1ns / 1ps

package pfe_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] ADDR_FADE_STEPS  = 2'd0;
    localparam logic [7:0] FADE_STEPS_RESET = 8'h80;

    typedef logic [15:0] chan_t;
    typedef chan_t [2:0] rgb_acc_t;

    // Channel bits 1..4 go to accumulator bits 11..14, channel bit 0 to bit 10.
    function automatic rgb_acc_t unpack_colour(logic [14:0] colour);
        rgb_acc_t r;
        for (int c = 0; c < 3; c++)
        begin
            r[c] = {1'b0, colour[4*c +: 4], colour[12+c], 10'b0};
        end
        return r;
    endfunction

    function automatic logic [14:0] repack_colour(rgb_acc_t a);
        logic [14:0] r;
        for (int c = 0; c < 3; c++)
        begin
            r[4*c +: 4] = a[c][14:11];
            r[12+c]     = a[c][10];
        end
        return r;
    endfunction

    function automatic chan_t asr7(chan_t v);
        return 16'($signed(v) >>> 7);
    endfunction

endpackage

>>> design/pfe_regs.sv
`timescale 1ns / 1ps

module pfe_regs
    import pfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  fade_steps
);

    logic [7:0] fade_steps_reg;
    logic [7:0] fade_steps_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == ADDR_FADE_STEPS);

    always_comb
    begin
        fade_steps_next = wr_en ? pwdata[7:0] : fade_steps_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_steps_reg <= FADE_STEPS_RESET;
        end
        else
        begin
            fade_steps_reg <= fade_steps_next;
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr == ADDR_FADE_STEPS)
        begin
            prdata = {24'd0, fade_steps_reg};
        end
    end

    assign fade_steps = fade_steps_reg;

endmodule

>>> design/pfe_store.sv
`timescale 1ns / 1ps

module pfe_store
    import pfe_pkg::*;
#(
    parameter int ENTRIES = 24,
    parameter int AW      = 5
)
(
    input  logic          clk,
    input  logic          we,
    input  logic          step_we,
    input  logic [AW-1:0] waddr,
    input  rgb_acc_t      wacc,
    input  rgb_acc_t      wstep,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output rgb_acc_t      racc,
    output rgb_acc_t      rstep
);

    rgb_acc_t acc_mem  [ENTRIES];
    rgb_acc_t step_mem [ENTRIES];
    rgb_acc_t racc_reg;
    rgb_acc_t rstep_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            acc_mem[waddr] <= wacc;
        end
        if (step_we)
        begin
            step_mem[waddr] <= wstep;
        end
    end

    // Hold read data until the next read so a stalled entry keeps its operands.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            racc_reg  <= acc_mem[raddr];
            rstep_reg <= step_mem[raddr];
        end
    end

    assign racc  = racc_reg;
    assign rstep = rstep_reg;

endmodule

>>> design/pfe_alu.sv
`timescale 1ns / 1ps

module pfe_alu
    import pfe_pkg::*;
(
    input  logic     sub,
    input  rgb_acc_t a,
    input  rgb_acc_t b,
    output rgb_acc_t res
);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            res[c] = sub ? (a[c] - b[c]) : (a[c] + b[c]);
        end
    end

endmodule

>>> design/palette_fade_engine_core.sv
`timescale 1ns / 1ps

// Linear palette fader for ENTRIES colours (1..32) in the packed 15-bit format. An armed tick
// walks the palette one entry per cycle while the output is not stalled, through one shared
// 3-channel adder fed by the registered read port of the colour store, giving ENTRIES results.
// in_stall is high for the whole walk. A tick while no fade is armed, and opcode 3, give no
// result.
module palette_fade_engine_core
    import pfe_pkg::*;
#(
    parameter int ENTRIES = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [4:0]  entry_index,
    input  logic [14:0] current_colour,
    input  logic [14:0] target_colour,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  out_index,
    output logic [14:0] out_colour,
    output logic        last,
    output logic        fade_done
);

    localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNTW = $clog2(ENTRIES + 1);

    logic [7:0]      fade_steps;
    logic            in_accept;
    logic            load_fire;
    logic            start_fire;
    logic            tick_fire;
    logic            issue_fire;
    logic            add_fire;
    logic            add_last;

    logic            run_reg;
    logic            run_next;
    logic            active_reg;
    logic            active_next;
    logic [7:0]      ticks_reg;
    logic [7:0]      ticks_next;
    logic            done_reg;
    logic            done_next;
    logic [CNTW-1:0] issue_cnt_reg;
    logic [CNTW-1:0] issue_cnt_next;
    logic            pend_reg;
    logic            pend_next;
    logic [AW-1:0]   pend_addr_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [4:0]      out_index_reg;
    logic [14:0]     out_colour_reg;
    logic            last_reg;
    logic            fade_done_reg;

    rgb_acc_t        cur_unp;
    rgb_acc_t        tgt_unp;
    rgb_acc_t        rd_acc;
    rgb_acc_t        rd_step;
    rgb_acc_t        alu_a;
    rgb_acc_t        alu_b;
    rgb_acc_t        alu_res;
    rgb_acc_t        load_step;
    rgb_acc_t        wr_acc;
    logic [AW-1:0]   wr_addr;

    pfe_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .fade_steps (fade_steps)
    );

    assign in_stall   = run_reg;
    assign in_accept  = in_valid && !in_stall;
    assign load_fire  = in_accept && (opcode == OP_LOAD)
                        && ({2'b00, entry_index} < 7'(ENTRIES));
    assign start_fire = in_accept && (opcode == OP_START);
    assign tick_fire  = in_accept && (opcode == OP_TICK) && active_reg;

    assign add_fire   = run_reg && pend_reg && (!out_valid_reg || !out_stall);
    assign issue_fire = run_reg && (issue_cnt_reg != CNTW'(ENTRIES)) && (!pend_reg || add_fire);
    assign add_last   = (pend_addr_reg == AW'(ENTRIES - 1));

    assign cur_unp = unpack_colour(current_colour);
    assign tgt_unp = unpack_colour(target_colour);

    // Share the adder: subtract target minus current on a load, accumulate on a tick.
    assign alu_a = run_reg ? rd_acc  : tgt_unp;
    assign alu_b = run_reg ? rd_step : cur_unp;

    pfe_alu u_alu (
        .sub (!run_reg),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            load_step[c] = asr7(alu_res[c]);
        end
    end

    assign wr_addr = run_reg ? pend_addr_reg : AW'(entry_index);
    assign wr_acc  = run_reg ? alu_res : cur_unp;

    pfe_store #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_store (
        .clk     (clk),
        .we      (load_fire || add_fire),
        .step_we (load_fire),
        .waddr   (wr_addr),
        .wacc    (wr_acc),
        .wstep   (load_step),
        .re      (issue_fire),
        .raddr   (issue_cnt_reg[AW-1:0]),
        .racc    (rd_acc),
        .rstep   (rd_step)
    );

    always_comb
    begin
        run_next       = run_reg;
        active_next    = active_reg;
        ticks_next     = ticks_reg;
        done_next      = done_reg;
        issue_cnt_next = issue_cnt_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;

        if (start_fire)
        begin
            ticks_next  = fade_steps;
            active_next = 1'b1;
        end

        if (tick_fire)
        begin
            ticks_next     = ticks_reg - 8'd1;
            done_next      = (ticks_reg == 8'd1);
            active_next    = (ticks_reg != 8'd1);
            run_next       = 1'b1;
            issue_cnt_next = '0;
            pend_next      = 1'b0;
        end

        if (issue_fire)
        begin
            issue_cnt_next = issue_cnt_reg + CNTW'(1);
            pend_next      = 1'b1;
        end
        else if (add_fire)
        begin
            pend_next = 1'b0;
        end

        if (add_fire && add_last)
        begin
            run_next = 1'b0;
        end

        if (add_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            active_reg    <= 1'b0;
            ticks_reg     <= 8'd0;
            done_reg      <= 1'b0;
            issue_cnt_reg <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg       <= run_next;
            active_reg    <= active_next;
            ticks_reg     <= ticks_next;
            done_reg      <= done_next;
            issue_cnt_reg <= issue_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_fire)
        begin
            pend_addr_reg <= issue_cnt_reg[AW-1:0];
        end
        if (add_fire)
        begin
            out_index_reg  <= 5'(pend_addr_reg);
            out_colour_reg <= repack_colour(alu_res);
            last_reg       <= add_last;
            fade_done_reg  <= add_last && done_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_index  = out_index_reg;
    assign out_colour = out_colour_reg;
    assign last       = last_reg;
    assign fade_done  = fade_done_reg;

endmodule

>>> design/pfe_checker.sv
`timescale 1ns / 1ps

module pfe_checker
#(
    parameter int ENTRIES = 24
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [4:0]  out_index,
    input logic [14:0] out_colour,
    input logic        last,
    input logic        fade_done
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_index) && $stable(out_colour))
        else $error("stalled result changed");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> out_index == 5'(ENTRIES - 1))
        else $error("last flag on wrong entry");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fade_done |-> last)
        else $error("fade_done without last");

    a_busy_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("input taken in the middle of a tick");

endmodule

bind palette_fade_engine_core pfe_checker #(.ENTRIES(ENTRIES)) u_pfe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_index  (out_index),
    .out_colour (out_colour),
    .last       (last),
    .fade_done  (fade_done)
);

>>> bench/tb_palette_fade_engine_core.sv
`timescale 1ns / 1ps

module tb_palette_fade_engine_core;
    import pfe_pkg::*;

    localparam int ENTRIES        = 24;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 22;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [4:0]  index;
        logic [14:0] colour;
        logic        is_last;
        logic        done;
    } fade_result_t;

    class fade_scoreboard;
        logic [15:0]  level [ENTRIES][3];
        logic [15:0]  slope [ENTRIES][3];
        logic [7:0]   ticks_left;
        logic [7:0]   steps_cfg;
        bit           armed;
        fade_result_t colour_q[$];
        int           errors;

        function new();
            ticks_left = '0;
            steps_cfg  = FADE_STEPS_RESET;
            armed      = 0;
            errors     = 0;
        endfunction

        // 5-bit channel into bits 10..14 of a 16-bit level
        function logic [15:0] widen(logic [14:0] colour, int c);
            logic [15:0] w;
            w = 16'(colour >> (4 * c)) & 16'h000F;
            w = ((w << 1) | 16'(colour[12 + c])) << 10;
            return w;
        endfunction

        function logic [15:0] shift_down7(logic [15:0] v);
            return {{7{v[15]}}, v[15:7]};
        endfunction

        function logic [14:0] pack(int e);
            logic [14:0] r;
            r = '0;
            for (int c = 0; c < 3; c++)
            begin
                r = r | (15'((level[e][c] >> 11) & 16'h000F) << (4 * c));
                r = r | (15'((level[e][c] >> 10) & 16'h0001) << (12 + c));
            end
            return r;
        endfunction

        function void set_steps(logic [7:0] v);
            steps_cfg = v;
        endfunction

        function void note_input(logic [1:0] op, logic [4:0] idx,
                                 logic [14:0] cur, logic [14:0] tgt);
            logic [15:0]  a;
            logic [15:0]  b;
            fade_result_t r;
            case (op)
                OP_LOAD:
                begin
                    if (int'(idx) < ENTRIES)
                    begin
                        for (int c = 0; c < 3; c++)
                        begin
                            a = widen(cur, c);
                            b = widen(tgt, c);
                            level[idx][c] = a;
                            slope[idx][c] = shift_down7(b - a);
                        end
                    end
                end
                OP_START:
                begin
                    ticks_left = steps_cfg;
                    armed      = 1;
                end
                OP_TICK:
                begin
                    if (armed)
                    begin
                        ticks_left = ticks_left - 8'd1;
                        for (int e = 0; e < ENTRIES; e++)
                        begin
                            for (int c = 0; c < 3; c++)
                                level[e][c] = level[e][c] + slope[e][c];
                            r.index   = 5'(e);
                            r.colour  = pack(e);
                            r.is_last = (e == ENTRIES - 1);
                            r.done    = (e == ENTRIES - 1) && (ticks_left == 8'd0);
                            colour_q.push_back(r);
                        end
                        if (ticks_left == 8'd0)
                            armed = 0;
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [4:0] idx, logic [14:0] colour, logic lst, logic done);
            fade_result_t want;
            if (colour_q.size() == 0)
            begin
                report($sformatf("unexpected result index %0d colour %h", idx, colour));
            end
            else
            begin
                want = colour_q.pop_front();
                if (idx !== want.index)
                    report($sformatf("out_index %0d, want %0d", idx, want.index));
                if (colour !== want.colour)
                    report($sformatf("entry %0d out_colour %h, want %h",
                                     want.index, colour, want.colour));
                if (lst !== want.is_last)
                    report($sformatf("entry %0d last %b, want %b", want.index, lst,
                                     want.is_last));
                if (done !== want.done)
                    report($sformatf("entry %0d fade_done %b, want %b", want.index, done,
                                     want.done));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic [4:0]  entry_index;
    logic [14:0] current_colour;
    logic [14:0] target_colour;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [4:0]  out_index;
    logic [14:0] out_colour;
    logic        last;
    logic        fade_done;

    fade_scoreboard sb;
    bit tx_gaps;
    bit rx_gaps      = 1'b0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    palette_fade_engine_core #(.ENTRIES(ENTRIES)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .entry_index    (entry_index),
        .current_colour (current_colour),
        .target_colour  (target_colour),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_index      (out_index),
        .out_colour     (out_colour),
        .last           (last),
        .fade_done      (fade_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int short_or_long(int lo, int hi);
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(lo, hi);
    endfunction

    function automatic logic [14:0] pick_colour();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return 15'h0000;
        if (r == 1)
            return 15'h7FFF;
        return 15'($urandom);
    endfunction

    // receiver: random stalls, plus one long hold when asked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (holds_served != hold_requests)
            begin
                holds_served <= hold_requests;
                hold_left    <= LONG_HOLD;
                out_stall    <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (rx_gaps && $urandom_range(0, 99) < 20)
            begin
                hold_left <= short_or_long(8, 30) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(out_index, out_colour, last, fade_done);
            if (in_valid && !in_stall)
                sb.note_input(opcode, entry_index, current_colour, target_colour);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [4:0] idx,
                             input logic [14:0] cur, input logic [14:0] tgt);
        int gap;
        gap = tx_gaps ? ($urandom_range(0, 99) < 60 ? 0 : short_or_long(10, 40)) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        opcode         <= op;
        entry_index    <= idx;
        current_colour <= cur;
        target_colour  <= tgt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_random_item();
        int         r;
        logic [1:0] op;
        logic [4:0] idx;
        r   = $urandom_range(0, 99);
        idx = 5'($urandom_range(0, 31));
        if (r < 35)
        begin
            op = OP_TICK;
        end
        else if (r < 50)
        begin
            op = OP_START;
        end
        else if (r < 80)
        begin
            op  = OP_LOAD;
            idx = 5'($urandom_range(0, ENTRIES - 1));
        end
        else if (r < 88)
        begin
            op  = OP_LOAD;
            idx = 5'($urandom_range(ENTRIES, 31));
        end
        else if (r < 94)
        begin
            op = OP_UNUSED;
        end
        else
        begin
            op = 2'($urandom_range(0, 3));
        end
        send_item(op, idx, pick_colour(), pick_colour());
    endtask

    // drop valid, let the monitor log the last item, wait for every result,
    // then give the walk time to finish
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.colour_q.size() != 0)
            @(posedge clk);
        repeat (ENTRIES + 8) @(posedge clk);
    endtask

    task automatic write_fade_steps(input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FADE_STEPS;
        pwdata  <= {24'($urandom), v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_steps(v);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[7:0] !== v)
            sb.report($sformatf("fade_steps reads %h, want %h", prdata[7:0], v));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        logic [7:0]  steps;
        logic [14:0] cur;
        logic [14:0] tgt;
        sb             = new();
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        opcode         = OP_LOAD;
        entry_index    = '0;
        current_colour = '0;
        target_colour  = '0;
        tx_gaps        = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle tick and unused opcode give nothing
        send_item(OP_TICK, 5'd31, 15'h7FFF, 15'h7FFF);
        send_item(OP_UNUSED, 5'd0, 15'h0000, 15'h0000);
        for (int e = 0; e < ENTRIES; e++)
        begin
            case (e % 4)
                0: begin cur = 15'h0000; tgt = 15'h7FFF; end
                1: begin cur = 15'h7FFF; tgt = 15'h0000; end
                2: begin cur = 15'h7FFF; tgt = 15'h7FFF; end
                default: begin cur = pick_colour(); tgt = pick_colour(); end
            endcase
            send_item(OP_LOAD, 5'(e), cur, tgt);
        end
        // out-of-range loads are ignored
        send_item(OP_LOAD, 5'd24, 15'h7FFF, 15'h0000);
        send_item(OP_LOAD, 5'd31, 15'h0000, 15'h7FFF);
        send_item(OP_START, 5'd0, 15'h0000, 15'h0000);
        send_item(OP_TICK, 5'd0, 15'h0000, 15'h0000);
        send_item(OP_LOAD, 5'd5, 15'h0000, 15'h7FFF);
        send_item(OP_TICK, 5'd0, 15'h0000, 15'h0000);
        send_item(OP_START, 5'd0, 15'h0000, 15'h0000);
        send_item(OP_TICK, 5'd0, 15'h0000, 15'h0000);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0: steps = 8'd1;
                1: steps = 8'd255;
                2: steps = 8'd2;
                3: steps = 8'd0;
                4: steps = 8'd3;
                default: steps = 8'($urandom_range(4, 12));
            endcase
            write_fade_steps(steps);
            tx_gaps = (p != 2);
            rx_gaps <= (p != 2);
            if (p == 1)
            begin
                // hold the output while ticks keep coming
                hold_requests <= hold_requests + 1;
                send_item(OP_START, 5'd0, pick_colour(), pick_colour());
                repeat (4) send_item(OP_TICK, 5'($urandom), pick_colour(), pick_colour());
            end
            else
            begin
                send_item(OP_START, 5'($urandom), pick_colour(), pick_colour());
            end
            repeat (PHASE_ITEMS) send_random_item();
        end

        settle();
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
design/pfe_pkg.sv
design/pfe_regs.sv
design/pfe_store.sv
design/pfe_alu.sv
design/palette_fade_engine_core.sv
design/pfe_checker.sv
bench/tb_palette_fade_engine_core.sv
